// ----- src/dsti_pkg.sv -----
`default_nettype none

package dsti_pkg;

    typedef logic signed [31:0] t_score;
    typedef logic [15:0]        t_tag;
    typedef logic [5:0]         t_rank;

    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/dsti_if.sv -----
`default_nettype none

interface dsti_in_if;
    import dsti_pkg::*;

    logic   valid;
    logic   ready;
    t_score new_score;
    t_tag   player_tag;

    modport source (output valid, output new_score, output player_tag, input ready);
    modport sink   (input valid, input new_score, input player_tag, output ready);
endinterface

interface dsti_out_if;
    import dsti_pkg::*;

    logic   valid;
    logic   ready;
    t_rank  rank_position;
    t_score entry_score;
    t_tag   entry_tag;
    logic   last_entry;
    logic   entry_dropped;

    modport source (output valid, output rank_position, output entry_score,
                    output entry_tag, output last_entry, output entry_dropped,
                    input ready);
    modport sink   (input valid, input rank_position, input entry_score,
                    input entry_tag, input last_entry, input entry_dropped,
                    output ready);
endinterface

`default_nettype wire

// ----- src/dsti_cell.sv -----
`default_nettype none

module dsti_cell (
    input  wire                  i_clk,
    input  dsti_pkg::t_cell_ctrl i_ctrl,
    input  wire                  i_occupied,
    input  dsti_pkg::t_score     i_new_score,
    input  dsti_pkg::t_tag       i_new_tag,
    input  wire                  i_prev_keep,
    input  dsti_pkg::t_score     i_prev_score,
    input  dsti_pkg::t_tag       i_prev_tag,
    input  dsti_pkg::t_score     i_next_score,
    input  dsti_pkg::t_tag       i_next_tag,
    output dsti_pkg::t_score     o_score,
    output dsti_pkg::t_tag       o_tag,
    output logic                 o_keep
);
    import dsti_pkg::*;

    t_score r_score;
    t_tag   r_tag;
    t_score n_score;
    t_tag   n_tag;

    // entry stays put when it ranks at or above the new word
    assign o_keep = i_occupied && (r_score >= i_new_score);

    always_comb begin
        n_score = r_score;
        n_tag   = r_tag;
        if (i_ctrl.insert) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_score = i_new_score;
                    n_tag   = i_new_tag;
                end else begin
                    n_score = i_prev_score;
                    n_tag   = i_prev_tag;
                end
            end
        end else if (i_ctrl.rotate) begin
            n_score = i_next_score;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_score = r_score;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ----- src/descending_score_table_insert.sv -----
// descending_score_table_insert
// Ranked table of up to CAPACITY entries (score, tag), highest score first.
// Input channel i_in carries one entry per word; output channel o_out carries
// the whole ranked table after each insert, one word per position from rank 0,
// with last_entry on the final word and entry_dropped on every word of an
// insert that pushed an entry out of a full table. Equal scores keep arrival
// order. Each cell of the chain compares its entry with the new score and
// either holds, takes the new entry or takes its upper neighbour's entry.
// The first output word is offered the cycle after the input word is
// accepted. The table is then read out by rotating the cell chain towards
// cell 0, one position per cycle unless the receiver stalls; after the valid
// entries have been sent the chain keeps rotating until CAPACITY steps are
// done, and only then is the next insert taken.
// Input ready is high only while no table is being sent or rotated.
// A receiver stall freezes the rotation and holds the output word.
// Reset empties the table; entries are not cleared, only the fill count.
`default_nettype none

module descending_score_table_insert #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dsti_in_if.sink     i_in,
    dsti_out_if.source  o_out
);
    import dsti_pkg::*;

    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EMIT   = 2'd1;
    localparam logic [1:0] S_ROTATE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_dropped, n_dropped;

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;
    logic       w_last;
    t_cell_ctrl w_ctrl;

    t_score w_score [CAPACITY];
    t_tag   w_tag   [CAPACITY];
    logic   w_keep  [CAPACITY];

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_last    = (CNT_W'(r_step) == r_count - CNT_W'(1));
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_ctrl.insert = w_in_acc;
    assign w_ctrl.rotate = w_out_acc || (r_state == S_ROTATE);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam int NXT = (gi == CAPACITY - 1) ? 0 : gi + 1;
            logic   w_occ;
            logic   w_pkeep;
            t_score w_pscore;
            t_tag   w_ptag;

            assign w_occ = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_pkeep  = 1'b1;
                assign w_pscore = i_in.new_score;
                assign w_ptag   = i_in.player_tag;
            end else begin : g_body
                assign w_pkeep  = w_keep[gi-1];
                assign w_pscore = w_score[gi-1];
                assign w_ptag   = w_tag[gi-1];
            end

            dsti_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occupied   (w_occ),
                .i_new_score  (i_in.new_score),
                .i_new_tag    (i_in.player_tag),
                .i_prev_keep  (w_pkeep),
                .i_prev_score (w_pscore),
                .i_prev_tag   (w_ptag),
                .i_next_score (w_score[NXT]),
                .i_next_tag   (w_tag[NXT]),
                .o_score      (w_score[gi]),
                .o_tag        (w_tag[gi]),
                .o_keep       (w_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_count   = r_count;
        n_dropped = r_dropped;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state   = S_EMIT;
                    n_step    = '0;
                    n_dropped = w_full;
                    n_count   = w_full ? r_count : r_count + CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_step = r_step + STEP_W'(1);
                    if (w_last) begin
                        n_state = w_full ? S_IDLE : S_ROTATE;
                    end
                end
            end
            S_ROTATE: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_EMIT);
    assign o_out.rank_position  = t_rank'(r_step);
    assign o_out.entry_score    = w_score[0];
    assign o_out.entry_tag      = w_tag[0];
    assign o_out.last_entry     = w_last;
    assign o_out.entry_dropped  = r_dropped;

endmodule

`default_nettype wire

// ----- src/dsti_checker.sv -----
`default_nettype none

module dsti_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [5:0]  i_rank,
    input wire [31:0] i_score,
    input wire        i_last
);

    // no new word is taken while a table is being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while output valid");

    // every insert starts its table at rank 0 on the next cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> (i_out_valid && i_rank == 6'd0))
        else $error("table does not start at rank 0");

    // ranks count up by one within a table
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last)
        |=> (i_out_valid && i_rank == $past(i_rank) + 6'd1))
        else $error("rank sequence broken");

    // table ends after the last word
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last) |=> !i_out_valid)
        else $error("word after last entry");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_rank) && $stable(i_score) && $stable(i_last)))
        else $error("stalled output word changed");

endmodule

bind descending_score_table_insert dsti_checker u_dsti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rank      (o_out.rank_position),
    .i_score     (o_out.entry_score),
    .i_last      (o_out.last_entry)
);

`default_nettype wire

// ----- sim/descending_score_table_insert_tb.sv -----
`timescale 1ns / 100ps

module descending_score_table_insert_tb;
    import dsti_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 190;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        t_score score;
        t_tag   tag;
        bit     drain;
    } t_new_entry;

    typedef struct {
        t_rank  rank;
        t_score score;
        t_tag   tag;
        logic   last;
        logic   dropped;
    } t_rank_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dsti_in_if  in_ch ();
    dsti_out_if out_ch ();

    descending_score_table_insert #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_new_entry entry_q[$];
    t_rank_word ranked_q[$];

    t_score rank_score [TABLE_DEPTH];
    t_tag   rank_tag   [TABLE_DEPTH];
    int     rank_fill;

    int err_count   = 0;
    int cycle_count = 0;
    int n_accepted  = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ranked table after one insert, pushed as the words it should emit
    task automatic rank_insert(input t_score s, input t_tag t);
        int  pos;
        int  i;
        bit  dropped;
        t_rank_word w;
        pos = 0;
        dropped = 1'b0;
        while (pos < rank_fill && rank_score[pos] >= s)
            pos++;
        if (rank_fill < TABLE_DEPTH) begin
            for (i = rank_fill; i > pos; i--) begin
                rank_score[i] = rank_score[i-1];
                rank_tag[i]   = rank_tag[i-1];
            end
            rank_score[pos] = s;
            rank_tag[pos]   = t;
            rank_fill++;
        end else begin
            dropped = 1'b1;
            if (pos < TABLE_DEPTH) begin
                for (i = TABLE_DEPTH - 1; i > pos; i--) begin
                    rank_score[i] = rank_score[i-1];
                    rank_tag[i]   = rank_tag[i-1];
                end
                rank_score[pos] = s;
                rank_tag[pos]   = t;
            end
        end
        for (i = 0; i < rank_fill; i++) begin
            w.rank    = t_rank'(i);
            w.score   = rank_score[i];
            w.tag     = rank_tag[i];
            w.last    = (i + 1 == rank_fill);
            w.dropped = dropped;
            ranked_q  = {ranked_q, w};
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, what, exp_v, act_v);
            err_count++;
        end
    endtask

    function automatic t_new_entry pick_entry();
        t_new_entry e;
        int r;
        int d;
        r = $urandom_range(0, 99);
        d = $urandom_range(0, 64);
        if (r < 3 || rank_fill == 0 && r < 65)
            e.score = (r < 3) ? 32'sh8000_0000 : t_score'($urandom);
        else if (r < 6)
            e.score = 32'sh7fff_ffff;
        else if (r < 35)
            e.score = rank_score[$urandom_range(0, rank_fill - 1)];
        else if (r < 65)
            e.score = rank_score[$urandom_range(0, rank_fill - 1)] + t_score'(d - 32);
        else
            e.score = t_score'($urandom);
        e.tag   = t_tag'($urandom_range(0, 65535));
        e.drain = ($urandom_range(0, 99) < 5);
        return e;
    endfunction

    // driver: bursts of words with random gaps
    int     burst_left = 0;
    int     gap_left   = 0;
    logic   offer;
    t_new_entry head;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                head = entry_q.pop_front();
                rank_insert(head.score, head.tag);
                n_accepted <= n_accepted + 1;
                offer = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (entry_q.size() > 0 &&
                             (!entry_q[0].drain || ranked_q.size() == 0)) begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 10);
                    offer = 1'b1;
                    in_ch.new_score  <= entry_q[0].score;
                    in_ch.player_tag <= entry_q[0].tag;
                end
            end
            in_ch.valid <= offer;
        end
    end

    // long receiver hold-off, twice in the run
    int hold_left  = 0;
    int hold_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((hold_count == 0 && n_accepted >= 30) ||
                     (hold_count == 1 && n_accepted >= 140)) begin
            hold_left  <= 250;
            hold_count <= hold_count + 1;
        end
    end

    // monitor with its own stall pattern
    int mode_left   = 0;
    int rx_mode     = 0;
    int rx_period   = 2;
    int rx_phase    = 0;
    logic pattern_ok;
    t_rank_word want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (ranked_q.size() == 0) begin
                    $display("%0t unexpected word rank %0d score %0h tag %0h", $time,
                             out_ch.rank_position, out_ch.entry_score, out_ch.entry_tag);
                    err_count++;
                end else begin
                    want = ranked_q.pop_front();
                    check_field("rank_position", 32'(want.rank), 32'(out_ch.rank_position));
                    check_field("entry_score", want.score, out_ch.entry_score);
                    check_field("entry_tag", 32'(want.tag), 32'(out_ch.entry_tag));
                    check_field("last_entry", 32'(want.last), 32'(out_ch.last_entry));
                    check_field("entry_dropped", 32'(want.dropped),
                                32'(out_ch.entry_dropped));
                end
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                rx_period = $urandom_range(2, 6);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                0: pattern_ok = 1'b1;
                1: pattern_ok = ($urandom_range(0, 9) < 7);
                default: pattern_ok = ((rx_phase % rx_period) != 0);
            endcase
            out_ch.ready <= pattern_ok && (hold_left == 0);
        end
    end

    task automatic queue_entry(input t_score s, input t_tag t, input bit drain);
        t_new_entry e;
        e.score = s;
        e.tag   = t;
        e.drain = drain;
        entry_q = {entry_q, e};
    endtask

    int k;

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.new_score  = '0;
        in_ch.player_tag = '0;
        out_ch.ready     = 1'b0;
        rank_fill        = 0;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            rank_score[k] = '0;
            rank_tag[k]   = '0;
        end

        // extremes and ties while the table fills
        queue_entry(32'sh8000_0000, 16'h0000, 1'b0);
        queue_entry(32'sh7fff_ffff, 16'hffff, 1'b0);
        queue_entry(32'sh0000_0000, 16'h0001, 1'b0);
        queue_entry(-32'sd1,        16'h0002, 1'b0);
        queue_entry(32'sh7fff_ffff, 16'h0003, 1'b0);
        queue_entry(32'sh8000_0000, 16'h0004, 1'b0);
        queue_entry(32'sh0000_0000, 16'h0005, 1'b0);
        for (k = 0; k < 9; k++)
            queue_entry(t_score'(k * 100 - 400), t_tag'(16'h0100 + k), 1'b0);
        // full table: new entry ties the bottom and falls out itself
        queue_entry(32'sh8000_0000, 16'haaaa, 1'b0);
        // full table: new maximum-score entry pushes out the bottom
        queue_entry(32'sh7fff_ffff, 16'h5555, 1'b0);
        queue_entry(-32'sd1,        16'h1234, 1'b0);
        queue_entry(32'sh0000_0007, 16'h4321, 1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (entry_q.size() > 0)
            @(posedge i_clk);

        k = 0;
        while (k < RANDOM_WORDS) begin
            @(posedge i_clk);
            if (entry_q.size() < 4) begin
                repeat (10) begin
                    entry_q = {entry_q, pick_entry()};
                    k++;
                end
            end
        end

        while (entry_q.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        while (ranked_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && ranked_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
